/* rtl/ppbm_pkg.sv */
// Package for point_projection_box_match: widths, codes, item structs.
// No dependencies.
package ppbm_pkg;
    localparam int MAX_BOXES = 32;
    localparam int BOX_AW = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_COEF = 2'd2;
    localparam logic [1:0] FUNC_PROJECT = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_DEPTH = 3'd1;
    localparam logic [2:0] ST_FRAME = 3'd2;
    localparam logic [2:0] ST_NOBOX = 3'd3;
    localparam logic [2:0] ST_MULTI = 3'd4;

    localparam logic [0:0] CFG_FRAME_WIDTH = 1'd0;
    localparam logic [0:0] CFG_MIN_DEPTH = 1'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [11:0]        box_left;
        logic [11:0]        box_top;
        logic [11:0]        box_width;
        logic [11:0]        box_height;
        logic [3:0]         coef_slot;
        logic signed [31:0] coef_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] proj_u;
        logic signed [31:0] proj_v;
        logic signed [31:0] depth;
        logic [4:0]         match_box;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } out_word_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

/* rtl/ppbm_if.sv */
// Valid/ready channel interfaces for input and result words.
// Depends on ppbm_pkg.
interface ppbm_in_if;
    logic valid;
    logic ready;
    ppbm_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppbm_out_if;
    logic valid;
    logic ready;
    ppbm_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/ppbm_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module ppbm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

/* rtl/ppbm_div.sv */
// Radix-2 restoring divider: quotient of 64-bit magnitude by 48-bit magnitude.
// One quotient bit per cycle. Depends on ppbm_pkg.
module ppbm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [47:0] den,
    output ppbm_pkg::div_ctl_t ctl,
    output logic [63:0] quot
);
    logic [63:0] q_reg;
    logic [48:0] rem_reg;
    logic [47:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] trial;
    logic [49:0] diff;

    assign trial = {rem_reg[47:0], q_reg[63]};
    assign diff = {1'b0, trial} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[49])
            begin
                rem_reg <= diff[48:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign quot = q_reg;
endmodule

/* rtl/point_projection_box_match.sv */
// Pinhole projection with bounding-box association.
// Non-project words are taken one per cycle. A project word runs a MAC pass over the 3x4
// matrix, a depth check, two divisions on the shared divider, a frame check, a read and a
// compare per stored box, and an output step; depth reject, frame reject and an empty
// table skip to the output step. One project word at a time; input is ready again
// when the result is loaded. Reset (async, active low) clears matrix, box count and
// config registers to defaults; box storage is not cleared.
module point_projection_box_match (
    input  logic                  clk,
    input  logic                  rst_n,
    ppbm_in_if.sink               in_ch,
    ppbm_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC = 4'd1;
    localparam logic [3:0] S_CHK = 4'd2;
    localparam logic [3:0] S_DIVU = 4'd3;
    localparam logic [3:0] S_WAITU = 4'd4;
    localparam logic [3:0] S_DIVV = 4'd5;
    localparam logic [3:0] S_WAITV = 4'd6;
    localparam logic [3:0] S_FRAME = 4'd7;
    localparam logic [3:0] S_RD = 4'd8;
    localparam logic [3:0] S_CMP = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;

    logic [3:0]  state_reg;
    logic [11:0] frame_width_reg;
    logic [15:0] min_depth_reg;
    logic signed [31:0] coef_reg [12];
    logic [ppbm_pkg::CNT_W-1:0] box_count_reg;
    ppbm_pkg::in_word_t item_reg;
    logic [3:0]  step_reg;
    logic signed [48:0] acc_reg [3];
    logic signed [31:0] u_reg, v_reg;
    logic [ppbm_pkg::CNT_W-1:0] bidx_reg;
    logic [1:0]  hits_reg;
    logic [ppbm_pkg::BOX_AW-1:0] match_reg;
    logic [2:0]  status_reg;
    ppbm_pkg::out_word_t res_reg;
    logic        res_valid_reg;
    logic        out_free;

    // shared MAC
    logic signed [31:0] mac_a, mac_b;
    logic signed [63:0] prod;
    logic signed [47:0] prod_sh;
    logic [1:0]  row;
    logic [1:0]  col;
    assign row = step_reg[3:2];
    assign col = step_reg[1:0];
    always_comb
    begin
        mac_a = coef_reg[4'(row * 4 + col)];
        case (col)
            2'd0: mac_b = item_reg.pos_x;
            2'd1: mac_b = item_reg.pos_y;
            2'd2: mac_b = item_reg.pos_z;
            default: mac_b = 32'sd65536;
        endcase
    end
    assign prod = mac_a * mac_b;
    assign prod_sh = prod[63:16];

    // depth
    logic signed [48:0] zval;
    logic [48:0] zmag;
    assign zval = acc_reg[2];
    assign zmag = zval[48] ? 49'(-zval) : zval;

    // divider
    logic div_start;
    logic [63:0] div_num;
    logic [63:0] div_q;
    logic signed [48:0] num_sel;
    logic [48:0] num_mag;
    ppbm_pkg::div_ctl_t div_ctl;
    assign num_sel = (state_reg == S_DIVU || state_reg == S_WAITU) ? acc_reg[0] : acc_reg[1];
    assign num_mag = num_sel[48] ? 49'(-num_sel) : num_sel;
    assign div_num = {num_mag[47:0], 16'd0};
    assign div_start = (state_reg == S_DIVU) || (state_reg == S_DIVV);

    ppbm_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(zmag[47:0]), .ctl(div_ctl), .quot(div_q)
    );

    logic neg_q;
    logic signed [31:0] q_sat;
    assign neg_q = num_sel[48] != zval[48];
    always_comb
    begin
        if (neg_q)
            q_sat = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_q);
        else
            q_sat = (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
    end

    // box table
    logic        ram_we;
    logic [ppbm_pkg::BOX_AW-1:0] ram_addr;
    logic [47:0] ram_rdata;
    logic        in_acc;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign ram_we = in_acc && in_ch.data.func == ppbm_pkg::FUNC_APPEND
                    && box_count_reg < ppbm_pkg::CNT_W'(ppbm_pkg::MAX_BOXES);
    assign ram_addr = ram_we ? box_count_reg[ppbm_pkg::BOX_AW-1:0]
                             : bidx_reg[ppbm_pkg::BOX_AW-1:0];

    ppbm_ram #(.WIDTH(48), .DEPTH(ppbm_pkg::MAX_BOXES)) u_boxes (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata({in_ch.data.box_left, in_ch.data.box_top,
                in_ch.data.box_width, in_ch.data.box_height}),
        .rdata(ram_rdata)
    );

    logic box_hit;
    logic [12:0] bl, bt, br, bb;
    assign bl = {1'b0, ram_rdata[47:36]};
    assign bt = {1'b0, ram_rdata[35:24]};
    assign br = bl + {1'b0, ram_rdata[23:12]};
    assign bb = bt + {1'b0, ram_rdata[11:0]};
    // u, v are positive-checked for u; v may be negative
    assign box_hit = ($signed({1'b0, u_reg}) >= $signed({1'b0, bl, 16'd0}))
                  && ($signed({1'b0, u_reg}) <= $signed({1'b0, br, 16'd0}))
                  && ($signed({v_reg[31], v_reg}) >= $signed({1'b0, bt, 16'd0}))
                  && ($signed({v_reg[31], v_reg}) <= $signed({1'b0, bb, 16'd0}));

    logic signed [31:0] zsat;
    assign zsat = (zval > 49'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (zval < -49'sh0_8000_0000) ? 32'sh8000_0000 : zval[31:0];

    // result register free for a new word this cycle
    assign out_free = !res_valid_reg || out_ch.ready;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            frame_width_reg <= 12'd640;
            min_depth_reg <= 16'd1;
            box_count_reg <= '0;
            res_valid_reg <= 1'b0;
            step_reg <= '0;
            for (int i = 0; i < 12; i++)
                coef_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ppbm_pkg::CFG_FRAME_WIDTH: frame_width_reg <= cfg_data[11:0];
                    ppbm_pkg::CFG_MIN_DEPTH: min_depth_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (res_valid_reg && out_ch.ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (in_ch.data.func)
                            ppbm_pkg::FUNC_CLEAR: box_count_reg <= '0;
                            ppbm_pkg::FUNC_APPEND:
                                if (ram_we)
                                    box_count_reg <= box_count_reg + 1'b1;
                            ppbm_pkg::FUNC_COEF:
                                if (in_ch.data.coef_slot < 4'd12)
                                    coef_reg[in_ch.data.coef_slot] <=
                                        in_ch.data.coef_value;
                            default:
                            begin
                                state_reg <= S_MAC;
                                step_reg <= '0;
                            end
                        endcase
                    end
                end
                S_MAC:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd11)
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (zval == 0 || zmag < {33'd0, min_depth_reg})
                    begin
                        u_reg <= '0;
                        v_reg <= '0;
                        status_reg <= ppbm_pkg::ST_DEPTH;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_DIVU;
                end
                S_DIVU: state_reg <= S_WAITU;
                S_WAITU:
                    if (div_ctl.done)
                    begin
                        u_reg <= q_sat;
                        state_reg <= S_DIVV;
                    end
                S_DIVV: state_reg <= S_WAITV;
                S_WAITV:
                    if (div_ctl.done)
                    begin
                        v_reg <= q_sat;
                        state_reg <= S_FRAME;
                    end
                S_FRAME:
                begin
                    bidx_reg <= '0;
                    hits_reg <= '0;
                    match_reg <= '0;
                    if (u_reg <= 0 || {1'b0, u_reg} >= {1'b0, frame_width_reg, 16'd0}
                        || u_reg[31])
                    begin
                        status_reg <= ppbm_pkg::ST_FRAME;
                        state_reg <= S_OUT;
                    end
                    else if (box_count_reg == '0)
                    begin
                        status_reg <= ppbm_pkg::ST_NOBOX;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_RD;
                end
                S_RD: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (box_hit)
                    begin
                        if (hits_reg != 2'd2)
                            hits_reg <= hits_reg + 2'd1;
                        match_reg <= bidx_reg[ppbm_pkg::BOX_AW-1:0];
                    end
                    if (bidx_reg + 1'b1 == box_count_reg)
                    begin
                        if (box_hit ? hits_reg == 2'd0 : hits_reg == 2'd1)
                            status_reg <= ppbm_pkg::ST_OK;
                        else if (!box_hit && hits_reg == 2'd0)
                            status_reg <= ppbm_pkg::ST_NOBOX;
                        else
                            status_reg <= ppbm_pkg::ST_MULTI;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        bidx_reg <= bidx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    // hold until the previous result word has left
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        res_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            item_reg <= in_ch.data;
        if (state_reg == S_IDLE)
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= '0;
        else if (state_reg == S_MAC)
            acc_reg[row] <= acc_reg[row] + ((col == 2'd3) ? 49'(mac_a) : 49'(prod_sh));
        if (state_reg == S_OUT && out_free)
        begin
            res_reg.status <= status_reg;
            res_reg.proj_u <= u_reg;
            res_reg.proj_v <= v_reg;
            res_reg.depth <= zsat;
            res_reg.match_box <= (status_reg == ppbm_pkg::ST_OK)
                                 ? 5'(match_reg) : 5'd0;
            res_reg.out_x <= item_reg.pos_x;
            res_reg.out_y <= item_reg.pos_y;
            res_reg.out_z <= item_reg.pos_z;
        end
    end
endmodule
